FILE: src/pfb_pkg.sv
// Shared types, constants and helpers for the page framebuffer with dirty-page flush.
package pfb_pkg;

    localparam int WIDTH_COLUMNS = 128;
    localparam int PAGE_TOTAL    = 8;

    localparam int COL_W   = $clog2(WIDTH_COLUMNS);
    localparam int DEPTH   = PAGE_TOTAL * WIDTH_COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W   = 15;

    localparam logic [2:0] OP_SET_PIXEL   = 3'd0;
    localparam logic [2:0] OP_CLEAR_ALL   = 3'd1;
    localparam logic [2:0] OP_CLEAR_PAGE  = 3'd2;
    localparam logic [2:0] OP_DRAW_BAR    = 3'd3;
    localparam logic [2:0] OP_SEND_TICK   = 3'd4;
    localparam logic [2:0] OP_PAGE_REPORT = 3'd5;

    localparam logic [7:0] CTRL_COMMAND      = 8'h00;
    localparam logic [7:0] CTRL_DATA         = 8'h40;
    localparam logic [7:0] CMD_COLUMN_WINDOW = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW   = 8'h22;
    localparam logic [7:0] COLUMN_FIRST      = 8'h00;
    localparam logic [7:0] COLUMN_LAST       = 8'(WIDTH_COLUMNS - 1);
    localparam logic [7:0] BAR_EDGE          = 8'h7F;
    localparam logic [7:0] BAR_OUTLINE       = 8'((1 << 0) | (1 << 6));
    localparam logic [7:0] BAR_FILL          = 8'((1 << 2) | (1 << 3) | (1 << 4));
    localparam logic [7:0] PERCENT_MAX       = 8'd100;
    localparam logic [7:0] CMD_XFER_LEN      = 8'd7;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] x_coord;
        logic [7:0] y_coord;
        logic       pixel_value;
        logic [7:0] page_number;
        logic [7:0] bar_level;
        logic       transfer_ok;
    } t_in_word;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       transfer_start;
        logic       transfer_end;
        logic       idle;
        logic [2:0] page_sent;
        logic       awaiting_report;
    } t_out_word;

    // Linear store address of one column byte of one page.
    function automatic logic [ADDR_W-1:0] store_addr(logic [2:0] page, logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(page) * ADDR_W'(WIDTH_COLUMNS)) + ADDR_W'(col);
    endfunction

endpackage

FILE: src/pfb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module pfb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/page_framebuffer_dirty_flush.sv
// Top level: page framebuffer with per-page dirty bits and a byte-serial flush stream.
//
// Usage: the input channel (i_in_valid / o_in_stall / i_in_word) takes one drawing,
// send-tick or page-report word at a time. Only a send tick produces an output word
// on o_out_valid / i_out_stall / o_out_word: the next byte of the flush stream (a
// 7-byte window command transfer, then 0x40 and the column bytes of the page), or
// an idle word. After the last data byte, idle words carry awaiting_report until a
// page report closes the page.
// Per word: a pixel write on a drawn page reads the byte and writes it back merged, on a
// blank page the page is swept to zero with the pixel merged in; a draw bar makes one
// store write per column; clear page, clear all and report finish on acceptance; a send
// tick fetches the column byte from the store, then loads the output.
// Clears are lazy: a per-page blank flag makes the page read as zero, so no sweep
// is spent on them. A send tick waits while a previous output word is still
// stalled, and other words wait behind it; everything else proceeds while a word
// sits in the output register.
// Reset: all pages blank and dirty, no page being sent, scan pointer at page 0.
// The store itself needs no clearing pass since blank flags cover it.
module page_framebuffer_dirty_flush (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pfb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pfb_pkg::t_out_word o_out_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_PIX,
        S_SWEEP
    } t_state;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_DATA,
        PH_AWAIT
    } t_phase;

    localparam int PT = pfb_pkg::PAGE_TOTAL;

    t_state r_state;

    // Flush sequencer state
    logic          r_send_active;
    logic [2:0]    r_send_page;
    t_phase        r_phase;
    logic [7:0]    r_cnt;
    logic [3:0]    r_scan;
    logic [PT-1:0] r_dirty;
    logic [PT-1:0] r_redrawn;
    logic [PT-1:0] r_blank;

    // Drawing sweep / read-modify-write context
    logic                     r_sweep_bar;
    logic [2:0]               r_work_page;
    logic [pfb_pkg::COL_W-1:0] r_col;
    logic [pfb_pkg::COL_W-1:0] r_pix_col;
    logic [7:0]               r_pix_mask;
    logic                     r_pix_val;
    logic [pfb_pkg::LIM_W-1:0] r_bar_lim;

    logic               r_out_valid;
    pfb_pkg::t_out_word r_out_word;

    // Store port
    logic                       mem_we;
    logic [pfb_pkg::ADDR_W-1:0] mem_waddr;
    logic [7:0]                 mem_wdata;
    logic                       mem_re;
    logic [pfb_pkg::ADDR_W-1:0] mem_raddr;
    logic [7:0]                 mem_rdata;

    pfb_ram #(
        .DATA_W(8),
        .DEPTH (pfb_pkg::DEPTH),
        .ADDR_W(pfb_pkg::ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Input decode
    logic       in_acc;
    logic       pix_ok;
    logic [2:0] pix_page;
    logic [7:0] pix_mask;
    logic       pg_ok;
    logic [2:0] pg_sel;
    logic [7:0] pct_sat;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign pix_ok   = (i_in_word.x_coord < 8'(pfb_pkg::WIDTH_COLUMNS))
                   && (i_in_word.y_coord < 8'(PT * 8));
    assign pix_page = i_in_word.y_coord[5:3];
    assign pix_mask = 8'd1 << i_in_word.y_coord[2:0];
    assign pg_ok    = i_in_word.page_number < 8'(PT);
    assign pg_sel   = i_in_word.page_number[2:0];
    assign pct_sat  = (i_in_word.bar_level > pfb_pkg::PERCENT_MAX)
                    ? pfb_pkg::PERCENT_MAX : i_in_word.bar_level;

    // Read issue: pixel fetch on a drawn page, or column fetch for a data byte
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = pfb_pkg::store_addr(r_send_page,
                        pfb_pkg::COL_W'(r_cnt - 8'd1));
        if (in_acc && i_in_word.operation == pfb_pkg::OP_SET_PIXEL && pix_ok
                && !r_blank[pix_page]) begin
            mem_re    = 1'b1;
            mem_raddr = pfb_pkg::store_addr(pix_page,
                            pfb_pkg::COL_W'(i_in_word.x_coord));
        end else if (in_acc && i_in_word.operation == pfb_pkg::OP_SEND_TICK
                && r_send_active && r_phase == PH_DATA && r_cnt != 8'd0) begin
            mem_re = 1'b1;
        end
    end

    // Write port: sweep writes one column a cycle, pixel merge writes once
    logic [pfb_pkg::LIM_W-1:0] col_scaled;
    logic [7:0]                bar_byte;
    logic                      sweep_last;

    assign col_scaled = pfb_pkg::LIM_W'(pfb_pkg::LIM_W'(r_col)
                      * pfb_pkg::LIM_W'(pfb_pkg::PERCENT_MAX));
    assign sweep_last = (r_col == pfb_pkg::COL_W'(pfb_pkg::WIDTH_COLUMNS - 1));

    always_comb begin
        if (r_col == '0 || sweep_last) begin
            bar_byte = pfb_pkg::BAR_EDGE;
        end else if (col_scaled <= r_bar_lim) begin
            bar_byte = pfb_pkg::BAR_OUTLINE | pfb_pkg::BAR_FILL;
        end else begin
            bar_byte = pfb_pkg::BAR_OUTLINE;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pfb_pkg::store_addr(r_work_page, r_col);
        mem_wdata = 8'h00;
        case (r_state)
            S_SWEEP: begin
                mem_we = 1'b1;
                if (r_sweep_bar) begin
                    mem_wdata = bar_byte;
                end else if (r_col == r_pix_col && r_pix_val) begin
                    mem_wdata = r_pix_mask;
                end else begin
                    mem_wdata = 8'h00;
                end
            end
            S_PIX: begin
                mem_we    = 1'b1;
                mem_waddr = pfb_pkg::store_addr(r_work_page, r_pix_col);
                mem_wdata = r_pix_val ? (mem_rdata | r_pix_mask)
                                      : (mem_rdata & ~r_pix_mask);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Send tick: pick a page if none is active, then form the next byte
    logic          pick_found;
    logic [2:0]    pick_page;
    logic          t_act;
    logic [2:0]    t_pg;
    t_phase        t_ph;
    logic [7:0]    t_cnt;
    pfb_pkg::t_out_word t_word;

    always_comb begin
        logic          hi_found;
        logic [2:0]    hi_page;
        logic          lo_found;
        logic [2:0]    lo_page;
        hi_found = 1'b0;
        hi_page  = 3'd0;
        lo_found = 1'b0;
        lo_page  = 3'd0;
        for (int p = PT - 1; p >= 0; p--) begin
            if (r_dirty[p]) begin
                lo_found = 1'b1;
                lo_page  = 3'(p);
                if (4'(p) >= r_scan) begin
                    hi_found = 1'b1;
                    hi_page  = 3'(p);
                end
            end
        end
        pick_found = lo_found;
        pick_page  = hi_found ? hi_page : lo_page;
    end

    always_comb begin
        t_act  = r_send_active;
        t_pg   = r_send_page;
        t_ph   = r_phase;
        t_cnt  = r_cnt;
        t_word = '0;
        if (!r_send_active && pick_found) begin
            t_act = 1'b1;
            t_pg  = pick_page;
            t_ph  = PH_CMD;
            t_cnt = 8'd0;
        end
        if (!t_act) begin
            t_word.idle = 1'b1;
        end else begin
            case (t_ph)
                PH_AWAIT: begin
                    t_word.idle            = 1'b1;
                    t_word.awaiting_report = 1'b1;
                    t_word.page_sent       = t_pg;
                end
                PH_CMD: begin
                    t_word.page_sent = t_pg;
                    case (t_cnt)
                        8'd0: begin
                            t_word.byte_value     = pfb_pkg::CTRL_COMMAND;
                            t_word.transfer_start = 1'b1;
                        end
                        8'd1:    t_word.byte_value = pfb_pkg::CMD_COLUMN_WINDOW;
                        8'd2:    t_word.byte_value = pfb_pkg::COLUMN_FIRST;
                        8'd3:    t_word.byte_value = pfb_pkg::COLUMN_LAST;
                        8'd4:    t_word.byte_value = pfb_pkg::CMD_PAGE_WINDOW;
                        default: t_word.byte_value = 8'(t_pg);
                    endcase
                    if (t_cnt + 8'd1 >= pfb_pkg::CMD_XFER_LEN) begin
                        t_word.transfer_end = 1'b1;
                        t_ph  = PH_DATA;
                        t_cnt = 8'd0;
                    end else begin
                        t_cnt = t_cnt + 8'd1;
                    end
                end
                PH_DATA: begin
                    t_word.page_sent = t_pg;
                    if (t_cnt == 8'd0) begin
                        t_word.byte_value     = pfb_pkg::CTRL_DATA;
                        t_word.transfer_start = 1'b1;
                    end else begin
                        t_word.byte_value = r_blank[t_pg] ? 8'h00 : mem_rdata;
                    end
                    if (t_cnt >= 8'(pfb_pkg::WIDTH_COLUMNS)) begin
                        t_word.transfer_end = 1'b1;
                        t_ph  = PH_AWAIT;
                        t_cnt = 8'd0;
                    end else begin
                        t_cnt = t_cnt + 8'd1;
                    end
                end
                default: begin
                    t_word.idle = 1'b1;
                end
            endcase
        end
    end

    // State, store context and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_send_active <= 1'b0;
            r_send_page   <= 3'd0;
            r_phase       <= PH_CMD;
            r_cnt         <= 8'd0;
            r_scan        <= 4'd0;
            r_dirty       <= '1;
            r_redrawn     <= '0;
            r_blank       <= '1;
            r_out_valid   <= 1'b0;
            r_col         <= '0;
        end else begin
            // Load a tick's word when the register is free, else drop it once taken
            if (r_state == S_TICK && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_word.operation)
                            pfb_pkg::OP_SET_PIXEL: begin
                                if (pix_ok) begin
                                    r_dirty[pix_page] <= 1'b1;
                                    if (r_send_active && r_send_page == pix_page) begin
                                        r_redrawn[pix_page] <= 1'b1;
                                    end
                                    r_work_page <= pix_page;
                                    r_pix_col   <= pfb_pkg::COL_W'(i_in_word.x_coord);
                                    r_pix_mask  <= pix_mask;
                                    r_pix_val   <= i_in_word.pixel_value;
                                    r_sweep_bar <= 1'b0;
                                    r_col       <= '0;
                                    if (r_blank[pix_page]) begin
                                        r_blank[pix_page] <= 1'b0;
                                        r_state           <= S_SWEEP;
                                    end else begin
                                        r_state <= S_PIX;
                                    end
                                end
                            end
                            pfb_pkg::OP_CLEAR_ALL: begin
                                r_blank <= '1;
                                r_dirty <= '1;
                                if (r_send_active) begin
                                    r_redrawn[r_send_page] <= 1'b1;
                                end
                            end
                            pfb_pkg::OP_CLEAR_PAGE: begin
                                if (pg_ok) begin
                                    r_blank[pg_sel] <= 1'b1;
                                    r_dirty[pg_sel] <= 1'b1;
                                    if (r_send_active && r_send_page == pg_sel) begin
                                        r_redrawn[pg_sel] <= 1'b1;
                                    end
                                end
                            end
                            pfb_pkg::OP_DRAW_BAR: begin
                                if (pg_ok) begin
                                    r_blank[pg_sel] <= 1'b0;
                                    r_dirty[pg_sel] <= 1'b1;
                                    if (r_send_active && r_send_page == pg_sel) begin
                                        r_redrawn[pg_sel] <= 1'b1;
                                    end
                                    // Column c is filled when c * 100 <= pct * (W - 2)
                                    r_bar_lim   <= pfb_pkg::LIM_W'(pfb_pkg::LIM_W'(pct_sat)
                                                 * pfb_pkg::LIM_W'(pfb_pkg::WIDTH_COLUMNS - 2));
                                    r_work_page <= pg_sel;
                                    r_sweep_bar <= 1'b1;
                                    r_col       <= '0;
                                    r_state     <= S_SWEEP;
                                end
                            end
                            pfb_pkg::OP_SEND_TICK: begin
                                r_state <= S_TICK;
                            end
                            pfb_pkg::OP_PAGE_REPORT: begin
                                if (r_send_active && r_phase == PH_AWAIT) begin
                                    if (i_in_word.transfer_ok && !r_redrawn[r_send_page]) begin
                                        r_dirty[r_send_page] <= 1'b0;
                                    end
                                    r_redrawn[r_send_page] <= 1'b0;
                                    r_scan        <= 4'(r_send_page) + 4'd1;
                                    r_send_active <= 1'b0;
                                    r_phase       <= PH_CMD;
                                    r_cnt         <= 8'd0;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    // Hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_word    <= t_word;
                        r_send_active <= t_act;
                        r_send_page   <= t_pg;
                        r_phase       <= t_ph;
                        r_cnt         <= t_cnt;
                        if (!r_send_active && pick_found) begin
                            r_redrawn[pick_page] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_PIX: begin
                    r_state <= S_IDLE;
                end
                S_SWEEP: begin
                    if (sweep_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_phase_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_send_active |-> (r_phase == PH_CMD && r_cnt == 8'd0))
        else $error("inactive sequencer left a phase or count behind");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_send_active && r_phase == PH_DATA) |-> (r_cnt <= 8'(pfb_pkg::WIDTH_COLUMNS)))
        else $error("data byte count ran past the last column");

    a_await_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.awaiting_report) |-> r_out_word.idle)
        else $error("awaiting report flagged on an emitting word");

    a_start_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.transfer_start || r_out_word.transfer_end))
            |-> !r_out_word.idle)
        else $error("transfer framing on an idle word");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && sweep_last) |=> (r_state == S_IDLE))
        else $error("store sweep did not finish after the last column");

endmodule

FILE: tb/sv/page_framebuffer_dirty_flush_checker.sv
// Checker for the page framebuffer: predicts the flush stream and compares output words.
`timescale 1ns / 100ps
module page_framebuffer_dirty_flush_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  pfb_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  pfb_pkg::t_out_word i_out_word,
    output int                 o_mismatch_count,
    output int                 o_pending_count
);

    typedef enum logic [1:0] {
        STREAM_COMMAND,
        STREAM_DATA,
        STREAM_AWAIT
    } t_stream_phase;

    logic [7:0]                     frame [pfb_pkg::PAGE_TOTAL][pfb_pkg::WIDTH_COLUMNS];
    logic [pfb_pkg::PAGE_TOTAL-1:0] dirty;
    logic [pfb_pkg::PAGE_TOTAL-1:0] redrawn;
    logic                           streaming;
    t_stream_phase                  phase;
    logic [2:0]                     stream_page;
    int                             stream_pos;
    logic [3:0]                     scan_from;
    pfb_pkg::t_out_word             expected_words [$];
    int                             mismatches;

    task automatic clear_model();
        for (int p = 0; p < pfb_pkg::PAGE_TOTAL; p++) begin
            for (int c = 0; c < pfb_pkg::WIDTH_COLUMNS; c++) begin
                frame[p][c] = 8'h00;
            end
        end
        dirty       = '1;
        redrawn     = '0;
        streaming   = 1'b0;
        phase       = STREAM_COMMAND;
        stream_page = 3'd0;
        stream_pos  = 0;
        scan_from   = 4'd0;
        expected_words.delete();
    endtask

    task automatic mark_dirty(input int p);
        dirty[p] = 1'b1;
        if (streaming && stream_page == 3'(p)) begin
            redrawn[p] = 1'b1;
        end
    endtask

    // Lowest dirty page at or after the scan pointer, else lowest overall.
    function automatic int pick_page();
        for (int p = int'(scan_from); p < pfb_pkg::PAGE_TOTAL; p++) begin
            if (dirty[p]) return p;
        end
        for (int p = 0; p < pfb_pkg::PAGE_TOTAL; p++) begin
            if (dirty[p]) return p;
        end
        return pfb_pkg::PAGE_TOTAL;
    endfunction

    task automatic next_stream_word(output pfb_pkg::t_out_word w);
        int p;
        int k;
        w = '0;
        if (!streaming) begin
            p = pick_page();
            if (p < pfb_pkg::PAGE_TOTAL) begin
                streaming   = 1'b1;
                stream_page = 3'(p);
                phase       = STREAM_COMMAND;
                stream_pos  = 0;
                redrawn[p]  = 1'b0;
            end
        end
        if (!streaming) begin
            w.idle = 1'b1;
        end else if (phase == STREAM_AWAIT) begin
            w.idle            = 1'b1;
            w.awaiting_report = 1'b1;
            w.page_sent       = stream_page;
        end else if (phase == STREAM_COMMAND) begin
            k           = stream_pos;
            w.page_sent = stream_page;
            case (k)
                0: begin
                    w.byte_value     = pfb_pkg::CTRL_COMMAND;
                    w.transfer_start = 1'b1;
                end
                1: w.byte_value = pfb_pkg::CMD_COLUMN_WINDOW;
                2: w.byte_value = pfb_pkg::COLUMN_FIRST;
                3: w.byte_value = pfb_pkg::COLUMN_LAST;
                4: w.byte_value = pfb_pkg::CMD_PAGE_WINDOW;
                default: w.byte_value = 8'(stream_page);
            endcase
            if (k + 1 >= int'(pfb_pkg::CMD_XFER_LEN)) begin
                w.transfer_end = 1'b1;
                phase          = STREAM_DATA;
                stream_pos     = 0;
            end else begin
                stream_pos = k + 1;
            end
        end else begin
            k           = stream_pos;
            w.page_sent = stream_page;
            if (k == 0) begin
                w.byte_value     = pfb_pkg::CTRL_DATA;
                w.transfer_start = 1'b1;
            end else begin
                w.byte_value = frame[stream_page][k-1];
            end
            if (k >= pfb_pkg::WIDTH_COLUMNS) begin
                w.transfer_end = 1'b1;
                phase          = STREAM_AWAIT;
                stream_pos     = 0;
            end else begin
                stream_pos = k + 1;
            end
        end
    endtask

    task automatic apply_word(input pfb_pkg::t_in_word w);
        int                 p;
        int                 pct;
        int                 filled;
        logic [7:0]         mask;
        pfb_pkg::t_out_word r;
        case (w.operation)
            pfb_pkg::OP_SET_PIXEL: begin
                if (w.x_coord < pfb_pkg::WIDTH_COLUMNS
                        && w.y_coord < pfb_pkg::PAGE_TOTAL * 8) begin
                    p    = int'(w.y_coord) >> 3;
                    mask = 8'(1 << w.y_coord[2:0]);
                    if (w.pixel_value) frame[p][w.x_coord] = frame[p][w.x_coord] | mask;
                    else               frame[p][w.x_coord] = frame[p][w.x_coord] & ~mask;
                    mark_dirty(p);
                end
            end
            pfb_pkg::OP_CLEAR_ALL: begin
                for (int q = 0; q < pfb_pkg::PAGE_TOTAL; q++) begin
                    for (int c = 0; c < pfb_pkg::WIDTH_COLUMNS; c++) frame[q][c] = 8'h00;
                    mark_dirty(q);
                end
            end
            pfb_pkg::OP_CLEAR_PAGE: begin
                if (w.page_number < pfb_pkg::PAGE_TOTAL) begin
                    for (int c = 0; c < pfb_pkg::WIDTH_COLUMNS; c++)
                        frame[w.page_number][c] = 8'h00;
                    mark_dirty(int'(w.page_number));
                end
            end
            pfb_pkg::OP_DRAW_BAR: begin
                if (w.page_number < pfb_pkg::PAGE_TOTAL) begin
                    pct    = (w.bar_level > pfb_pkg::PERCENT_MAX)
                           ? int'(pfb_pkg::PERCENT_MAX) : int'(w.bar_level);
                    filled = pct * (pfb_pkg::WIDTH_COLUMNS - 2) / int'(pfb_pkg::PERCENT_MAX);
                    for (int c = 0; c < pfb_pkg::WIDTH_COLUMNS; c++) begin
                        if (c == 0 || c == pfb_pkg::WIDTH_COLUMNS - 1)
                            frame[w.page_number][c] = pfb_pkg::BAR_EDGE;
                        else if (c <= filled)
                            frame[w.page_number][c] = pfb_pkg::BAR_OUTLINE | pfb_pkg::BAR_FILL;
                        else
                            frame[w.page_number][c] = pfb_pkg::BAR_OUTLINE;
                    end
                    mark_dirty(int'(w.page_number));
                end
            end
            pfb_pkg::OP_SEND_TICK: begin
                next_stream_word(r);
                expected_words.push_back(r);
            end
            pfb_pkg::OP_PAGE_REPORT: begin
                if (streaming && phase == STREAM_AWAIT) begin
                    p = int'(stream_page);
                    if (w.transfer_ok && !redrawn[p]) dirty[p] = 1'b0;
                    redrawn[p] = 1'b0;
                    scan_from  = 4'(p + 1);
                    streaming  = 1'b0;
                    phase      = STREAM_COMMAND;
                    stream_pos = 0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        pfb_pkg::t_out_word want;
        pfb_pkg::t_out_word got;
        logic               bad;
        if (!i_rst_n) begin
            clear_model();
            mismatches = 0;
        end else begin
            // A word leaving now was predicted by an earlier tick, so compare first.
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output word %h arrived with nothing expected",
                                 $realtime, got);
                end else begin
                    want = expected_words.pop_front();
                    bad  = (got.byte_value      !== want.byte_value)
                        || (got.transfer_start  !== want.transfer_start)
                        || (got.transfer_end    !== want.transfer_end)
                        || (got.idle            !== want.idle)
                        || (got.page_sent       !== want.page_sent)
                        || (got.awaiting_report !== want.awaiting_report);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch byte/start/end/idle/page/await ",
                                      "expected %h/%b/%b/%b/%0d/%b got %h/%b/%b/%b/%0d/%b"},
                                     $realtime,
                                     want.byte_value, want.transfer_start, want.transfer_end,
                                     want.idle, want.page_sent, want.awaiting_report,
                                     got.byte_value, got.transfer_start, got.transfer_end,
                                     got.idle, got.page_sent, got.awaiting_report);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_word(i_in_word);
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= expected_words.size();
    end

endmodule

FILE: tb/sv/page_framebuffer_dirty_flush_tb.sv
// Testbench top for the page framebuffer: drives drawing, tick and report words.
`timescale 1ns / 100ps
module page_framebuffer_dirty_flush_tb;

    // Codes 6 and 7 are unused by the block; send them to see that they are dropped.
    localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;

    localparam int ITEM_TARGET   = 950;
    localparam int DRAIN_FROM    = 600;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    pfb_pkg::t_in_word  in_word;
    logic               out_valid;
    logic               out_stall;
    pfb_pkg::t_out_word out_word;

    int        mismatch_count;
    int        pending_count;

    // Stimulus hints taken from the output side: the last accepted word asked for
    // a page report, and an idle word with nothing dirty has been seen.
    logic      last_await;
    logic      drained;
    int        burst_left;

    page_framebuffer_dirty_flush dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    page_framebuffer_dirty_flush_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_word        (in_word),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_word       (out_word),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop for a hung handshake.
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            last_await <= 1'b0;
            drained    <= 1'b0;
        end else if (out_valid && !out_stall) begin
            last_await <= out_word.awaiting_report;
            if (out_word.idle && !out_word.awaiting_report) drained <= 1'b1;
        end
    end

    // Output stall: mostly short bursts, a few long holds, and quiet stretches.
    initial begin : stall_gen
        int   hold;
        int   r;
        logic level;
        out_stall <= 1'b0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    level = 1'b0;
                    hold  = $urandom_range(40, 160);
                end else if (r < 50) begin
                    level = 1'b1;
                    hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    hold  = $urandom_range(1, 6);
                end
                out_stall <= level;
            end
            hold--;
        end
    end

    // Gap before the next input word: mostly none or short, sometimes long,
    // with occasional back-to-back bursts.
    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one word at the falling edge and hold it until it is taken.
    task automatic push_word(input pfb_pkg::t_in_word w);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic push_op(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
                           input logic v, input logic [7:0] pg, input logic [7:0] pct,
                           input logic ok);
        pfb_pkg::t_in_word w;
        w.operation   = op;
        w.x_coord     = x;
        w.y_coord     = y;
        w.pixel_value = v;
        w.page_number = pg;
        w.bar_level   = pct;
        w.transfer_ok = ok;
        push_word(w);
    endtask

    // Random word of the given operation: every field random, then the fields the
    // operation uses pulled mostly into range.
    function automatic pfb_pkg::t_in_word shaped_word(input logic [2:0] op);
        pfb_pkg::t_in_word w;
        w.operation   = op;
        w.x_coord     = 8'($urandom_range(0, 255));
        w.y_coord     = 8'($urandom_range(0, 255));
        w.pixel_value = 1'($urandom_range(0, 1));
        w.page_number = 8'($urandom_range(0, 255));
        w.bar_level   = 8'($urandom_range(0, 255));
        w.transfer_ok = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) != 0) begin
            w.x_coord     = 8'($urandom_range(0, pfb_pkg::WIDTH_COLUMNS - 1));
            w.y_coord     = 8'($urandom_range(0, pfb_pkg::PAGE_TOTAL * 8 - 1));
            w.page_number = 8'($urandom_range(0, pfb_pkg::PAGE_TOTAL - 1));
        end
        if ($urandom_range(0, 3) != 0) w.bar_level = 8'($urandom_range(0, 100));
        return w;
    endfunction

    initial begin : stimulus
        int                total;
        int                r;
        int                waited;
        pfb_pkg::t_in_word w;

        burst_left = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: open page 0, stray report, edge pixels, out-of-range pixels and
        // pages, bar extremes, clears and the unused codes.
        push_op(pfb_pkg::OP_SEND_TICK,   8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1);
        push_op(pfb_pkg::OP_PAGE_REPORT, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1);
        push_op(pfb_pkg::OP_SET_PIXEL,   8'd0,   8'd0,   1'b1, 8'h00, 8'h00, 1'b0);
        push_op(pfb_pkg::OP_SET_PIXEL,   8'd127, 8'd63,  1'b1, 8'hFF, 8'hFF, 1'b1);
        push_op(pfb_pkg::OP_SET_PIXEL,   8'd128, 8'd7,   1'b1, 8'h00, 8'h00, 1'b0);
        push_op(pfb_pkg::OP_SET_PIXEL,   8'd3,   8'd64,  1'b1, 8'h00, 8'h00, 1'b0);
        push_op(pfb_pkg::OP_SET_PIXEL,   8'd255, 8'd255, 1'b1, 8'h00, 8'h00, 1'b0);
        push_op(pfb_pkg::OP_SET_PIXEL,   8'd127, 8'd63,  1'b0, 8'h00, 8'h00, 1'b0);
        push_op(pfb_pkg::OP_DRAW_BAR,    8'h00, 8'h00, 1'b0, 8'd7,   8'd0,   1'b0);
        push_op(pfb_pkg::OP_DRAW_BAR,    8'hFF, 8'hFF, 1'b1, 8'd6,   8'd100, 1'b1);
        push_op(pfb_pkg::OP_DRAW_BAR,    8'h00, 8'h00, 1'b0, 8'd5,   8'd255, 1'b0);
        push_op(pfb_pkg::OP_DRAW_BAR,    8'h00, 8'h00, 1'b0, 8'd4,   8'd50,  1'b0);
        push_op(pfb_pkg::OP_DRAW_BAR,    8'h00, 8'h00, 1'b0, 8'd3,   8'd1,   1'b0);
        push_op(pfb_pkg::OP_DRAW_BAR,    8'h00, 8'h00, 1'b0, 8'd8,   8'd100, 1'b0);
        push_op(pfb_pkg::OP_DRAW_BAR,    8'h00, 8'h00, 1'b0, 8'd255, 8'd101, 1'b0);
        push_op(pfb_pkg::OP_CLEAR_PAGE,  8'h00, 8'h00, 1'b0, 8'd3,   8'h00, 1'b0);
        push_op(pfb_pkg::OP_CLEAR_PAGE,  8'h00, 8'h00, 1'b0, 8'd8,   8'h00, 1'b0);
        push_op(pfb_pkg::OP_CLEAR_PAGE,  8'h00, 8'h00, 1'b0, 8'd255, 8'h00, 1'b0);
        push_op(pfb_pkg::OP_CLEAR_ALL,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
        push_op(OP_SPARE_LOW,            8'd1,  8'd1,  1'b1, 8'd1,  8'd1,  1'b1);
        push_op(OP_SPARE_HIGH,           8'd2,  8'd2,  1'b1, 8'd2,  8'd2,  1'b1);
        repeat (3) push_op(pfb_pkg::OP_SEND_TICK, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);

        // Random: mostly send ticks that walk pages through the full stream, with
        // drawing mixed in (some of it on the page in flight) and reports once a
        // page waits. In the last stretch, drain with ticks and good reports until
        // an idle word with nothing dirty has come out.
        total = 0;
        while (total < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (total >= DRAIN_FROM && !drained) begin
                if (last_await) begin
                    w             = shaped_word(pfb_pkg::OP_PAGE_REPORT);
                    w.transfer_ok = 1'b1;
                end else begin
                    w = shaped_word(pfb_pkg::OP_SEND_TICK);
                end
            end else if (last_await && r < 60) begin
                w             = shaped_word(pfb_pkg::OP_PAGE_REPORT);
                w.transfer_ok = ($urandom_range(0, 7) != 0);
            end else begin
                r = $urandom_range(0, 99);
                if      (r < 64) w = shaped_word(pfb_pkg::OP_SEND_TICK);
                else if (r < 80) w = shaped_word(pfb_pkg::OP_SET_PIXEL);
                else if (r < 85) w = shaped_word(pfb_pkg::OP_DRAW_BAR);
                else if (r < 89) w = shaped_word(pfb_pkg::OP_CLEAR_PAGE);
                else if (r < 90) w = shaped_word(pfb_pkg::OP_CLEAR_ALL);
                else if (r < 95) w = shaped_word(pfb_pkg::OP_PAGE_REPORT);
                else if (r < 97) w = shaped_word(r[0] ? OP_SPARE_LOW : OP_SPARE_HIGH);
                else             w = shaped_word(pfb_pkg::OP_SET_PIXEL);
            end
            push_word(w);
            total++;
        end
        in_valid <= 1'b0;

        // Wait for every predicted word to come out, then let the pipe settle.
        waited = 0;
        while (pending_count != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/pfb_pkg.sv
src/pfb_ram.sv
src/page_framebuffer_dirty_flush.sv
tb/sv/page_framebuffer_dirty_flush_checker.sv
tb/sv/page_framebuffer_dirty_flush_tb.sv
